/* rtl/core/slrl_pkg.sv */
package slrl_pkg;

   // Default sizes of the source table and of each stamp ring
   localparam int DEF_SOURCES    = 64;
   localparam int DEF_RING_DEPTH = 16;

   // Field widths
   localparam int IP_W       = 32;
   localparam int TIME_W     = 48;
   localparam int WINDOW_W   = 32;
   localparam int MAXREQ_W   = 4;
   localparam int VERDICT_W  = 3;
   localparam int COUNT_W    = 5;
   localparam int REQ_DATA_W = IP_W + TIME_W;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // Register reset values
   localparam logic [WINDOW_W-1:0] DEF_WINDOW_MS    = 32'd600000;
   localparam logic [MAXREQ_W-1:0] DEF_MAX_REQUESTS = 4'd10;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_MS    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_REQUESTS = 8'd1;

   // Verdict codes
   localparam logic [VERDICT_W-1:0] VERDICT_SAFE       = 3'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_BLOCKED    = 3'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_NEW_BLOCK  = 3'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_NO_AGENT   = 3'd3;
   localparam logic [VERDICT_W-1:0] VERDICT_TABLE_FULL = 3'd4;

   // Write commands from the sequencer to the source table
   typedef struct packed {
      logic alloc;    // claim the next free entry for the current source
      logic meta_we;  // write blocked mark, count and ring head of an entry
   } tbl_cmd_type;

endpackage

/* rtl/core/sliding_window_source_rate_limiter.sv */
// Per-source request rate limiter over a sliding time window.
// req_* carries one request beat: tdata = source_ip[31:0], time_ms[79:32];
// tuser = has_agent. rsp_* returns one verdict beat per request:
// tdata = verdict[2:0], count_in_window[7:3]. csr_* writes window_ms
// (index 0) and max_requests (index 1); it is always ready and must be used
// only while no request is in flight.
// From acceptance to the next acceptance a known source passes through the
// key reads to find it (one per cycle), metadata read, decide, read and
// compare of the oldest stamp, verdict load and the idle state, with one more
// stamp read and compare for each expired stamp dropped. A new source scans
// all filled entries and adds an allocation step. A blocked or newly blocked
// source skips the stamp steps; a full table refuses after scanning every
// entry.
// req_tready is low from acceptance until the verdict is loaded into the
// output register; the next request may then be taken while that verdict
// still waits. If the receiver stalls with a verdict held, the following
// request runs to completion and waits for the output register to free.
// Reset empties the source table at once (fill count cleared), drops any
// held verdict and restores window_ms = 600000 and max_requests = 10.
module sliding_window_source_rate_limiter #(
   parameter int SOURCES    = slrl_pkg::DEF_SOURCES,
   parameter int RING_DEPTH = slrl_pkg::DEF_RING_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [slrl_pkg::REQ_DATA_W-1:0]     req_tdata,   // source_ip, time_ms
   input  logic                                req_tuser,   // has_agent
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [slrl_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // verdict, count_in_window
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [slrl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [slrl_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int IW = $clog2(SOURCES);
   localparam int FW = $clog2(SOURCES + 1);
   localparam int HW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(RING_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC,
      ST_META,
      ST_DECIDE,
      ST_EXP_RD,
      ST_EXP_CHK,
      ST_DONE
   } state_type;

   state_type                          state_ff;
   logic [slrl_pkg::IP_W-1:0]          ip_ff;
   logic [slrl_pkg::TIME_W-1:0]        time_ff;
   logic                               agent_ff;
   logic [IW-1:0]                      idx_ff;
   logic [IW-1:0]                      entry_ff;
   logic [CW-1:0]                      cnt_ff;
   logic [HW-1:0]                      head_ff;
   logic [slrl_pkg::VERDICT_W-1:0]     verdict_ff;
   logic [slrl_pkg::COUNT_W-1:0]       count_ff;
   logic                               rsp_valid_ff;
   logic [slrl_pkg::RSP_DATA_W-1:0]    rsp_data_ff;
   logic [slrl_pkg::WINDOW_W-1:0]      window_ff;
   logic [slrl_pkg::MAXREQ_W-1:0]      max_req_ff;

   slrl_pkg::tbl_cmd_type              cmd;
   logic [IW-1:0]                      key_rd_addr;
   logic [slrl_pkg::IP_W-1:0]          key_q;
   logic                               meta_blocked_q;
   logic [CW-1:0]                      meta_cnt_q;
   logic [HW-1:0]                      meta_head_q;
   logic [FW-1:0]                      fill;
   logic                               meta_wr_blocked;
   logic [CW-1:0]                      meta_wr_cnt;
   logic [HW-1:0]                      meta_wr_head;
   logic                               expired;
   logic                               stamp_we;

   logic                               table_full;
   logic                               scan_last;
   logic                               over_limit;
   logic                               drop;
   logic [HW-1:0]                      head_adj;
   logic [CW-1:0]                      cnt_adj;
   logic [HW:0]                        pos_sum;
   logic [HW-1:0]                      push_pos;
   logic [HW-1:0]                      head_next;

   // Decode search, limit and ring positions
   always_comb begin
      table_full = (fill == FW'(SOURCES));
      scan_last  = (FW'({1'b0, idx_ff}) + FW'(1) == fill);
      over_limit = (32'(meta_cnt_q) > 32'(max_req_ff));
      drop       = expired && (cnt_ff != '0);

      // Full ring: discard the oldest before appending
      if (meta_cnt_q >= CW'(RING_DEPTH)) begin
         head_adj = (meta_head_q == HW'(RING_DEPTH - 1)) ? '0 : meta_head_q + HW'(1);
         cnt_adj  = CW'(RING_DEPTH - 1);
      end else begin
         head_adj = meta_head_q;
         cnt_adj  = meta_cnt_q;
      end
      pos_sum  = {1'b0, head_adj} + (HW + 1)'(cnt_adj);
      push_pos = (pos_sum >= (HW + 1)'(RING_DEPTH)) ?
                 HW'(pos_sum - (HW + 1)'(RING_DEPTH)) : pos_sum[HW-1:0];

      head_next = (head_ff == HW'(RING_DEPTH - 1)) ? '0 : head_ff + HW'(1);
   end

   // Drive memory ports from the sequencer state
   always_comb begin
      key_rd_addr     = (state_ff == ST_SCAN) ? idx_ff + IW'(1) : '0;
      cmd.alloc       = (state_ff == ST_ALLOC) && !table_full;
      cmd.meta_we     = ((state_ff == ST_DECIDE) && !meta_blocked_q && over_limit) ||
                        ((state_ff == ST_EXP_CHK) && !drop);
      meta_wr_blocked = (state_ff == ST_DECIDE);
      meta_wr_cnt     = (state_ff == ST_DECIDE) ? meta_cnt_q : cnt_ff;
      meta_wr_head    = (state_ff == ST_DECIDE) ? meta_head_q : head_ff;
      stamp_we        = (state_ff == ST_DECIDE) && !meta_blocked_q && !over_limit;
   end

   slrl_src_table #(
      .SOURCES    (SOURCES),
      .RING_DEPTH (RING_DEPTH)
   ) u_src_table (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .key_rd_addr     (key_rd_addr),
      .alloc_key       (ip_ff),
      .meta_addr       (entry_ff),
      .meta_wr_blocked (meta_wr_blocked),
      .meta_wr_cnt     (meta_wr_cnt),
      .meta_wr_head    (meta_wr_head),
      .key_q           (key_q),
      .meta_blocked_q  (meta_blocked_q),
      .meta_cnt_q      (meta_cnt_q),
      .meta_head_q     (meta_head_q),
      .fill            (fill)
   );

   slrl_stamp_ring #(
      .SOURCES    (SOURCES),
      .RING_DEPTH (RING_DEPTH)
   ) u_stamp_ring (
      .clock   (clock),
      .entry   (entry_ff),
      .wr_en   (stamp_we),
      .wr_pos  (push_pos),
      .rd_pos  (head_ff),
      .now     (time_ff),
      .window  (window_ff),
      .expired (expired)
   );

   // Sequencer, configuration registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         window_ff    <= slrl_pkg::DEF_WINDOW_MS;
         max_req_ff   <= slrl_pkg::DEF_MAX_REQUESTS;
      end else begin
         if (csr_valid) begin
            if (csr_index == slrl_pkg::CSR_WINDOW_MS) begin
               window_ff <= csr_data;
            end else if (csr_index == slrl_pkg::CSR_MAX_REQUESTS) begin
               max_req_ff <= csr_data[slrl_pkg::MAXREQ_W-1:0];
            end
         end

         // Release the held verdict unless a new one is loaded this cycle
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  ip_ff    <= req_tdata[slrl_pkg::IP_W-1:0];
                  time_ff  <= req_tdata[slrl_pkg::REQ_DATA_W-1:slrl_pkg::IP_W];
                  agent_ff <= req_tuser;
                  idx_ff   <= '0;
                  state_ff <= (fill == '0) ? ST_ALLOC : ST_SCAN;
               end
            end
            ST_SCAN: begin
               // Compare one stored key per cycle
               if (key_q == ip_ff) begin
                  entry_ff <= idx_ff;
                  state_ff <= ST_META;
               end else if (scan_last) begin
                  state_ff <= ST_ALLOC;
               end else begin
                  idx_ff <= idx_ff + IW'(1);
               end
            end
            ST_ALLOC: begin
               if (table_full) begin
                  verdict_ff <= slrl_pkg::VERDICT_TABLE_FULL;
                  count_ff   <= '0;
                  state_ff   <= ST_DONE;
               end else begin
                  entry_ff <= fill[IW-1:0];
                  state_ff <= ST_META;
               end
            end
            ST_META: begin
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (meta_blocked_q) begin
                  verdict_ff <= slrl_pkg::VERDICT_BLOCKED;
                  count_ff   <= slrl_pkg::COUNT_W'(meta_cnt_q);
                  state_ff   <= ST_DONE;
               end else if (over_limit) begin
                  verdict_ff <= slrl_pkg::VERDICT_NEW_BLOCK;
                  count_ff   <= slrl_pkg::COUNT_W'(meta_cnt_q);
                  state_ff   <= ST_DONE;
               end else begin
                  cnt_ff   <= cnt_adj + CW'(1);
                  head_ff  <= head_adj;
                  state_ff <= ST_EXP_RD;
               end
            end
            ST_EXP_RD: begin
               state_ff <= ST_EXP_CHK;
            end
            ST_EXP_CHK: begin
               // Drop the oldest stamp while it lies outside the window
               if (drop) begin
                  head_ff  <= head_next;
                  cnt_ff   <= cnt_ff - CW'(1);
                  state_ff <= ST_EXP_RD;
               end else begin
                  verdict_ff <= agent_ff ? slrl_pkg::VERDICT_SAFE : slrl_pkg::VERDICT_NO_AGENT;
                  count_ff   <= slrl_pkg::COUNT_W'(cnt_ff);
                  state_ff   <= ST_DONE;
               end
            end
            ST_DONE: begin
               // Hold until the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {count_ff, verdict_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

/* rtl/core/slrl_src_table.sv */
module slrl_src_table #(
   parameter int SOURCES    = slrl_pkg::DEF_SOURCES,
   parameter int RING_DEPTH = slrl_pkg::DEF_RING_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  slrl_pkg::tbl_cmd_type              cmd,
   input  logic [$clog2(SOURCES)-1:0]         key_rd_addr,
   input  logic [slrl_pkg::IP_W-1:0]          alloc_key,
   input  logic [$clog2(SOURCES)-1:0]         meta_addr,
   input  logic                               meta_wr_blocked,
   input  logic [$clog2(RING_DEPTH+1)-1:0]    meta_wr_cnt,
   input  logic [$clog2(RING_DEPTH)-1:0]      meta_wr_head,
   output logic [slrl_pkg::IP_W-1:0]          key_q,
   output logic                               meta_blocked_q,
   output logic [$clog2(RING_DEPTH+1)-1:0]    meta_cnt_q,
   output logic [$clog2(RING_DEPTH)-1:0]      meta_head_q,
   output logic [$clog2(SOURCES+1)-1:0]       fill
);

   localparam int IW = $clog2(SOURCES);
   localparam int FW = $clog2(SOURCES + 1);
   localparam int HW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int MW = 1 + CW + HW;

   logic [slrl_pkg::IP_W-1:0] key_mem [SOURCES];
   logic [MW-1:0]             meta_mem [SOURCES];
   logic [slrl_pkg::IP_W-1:0] key_q_ff;
   logic [MW-1:0]             meta_q_ff;
   logic [FW-1:0]             fill_ff;
   logic [FW-1:0]             fill_in;
   logic [IW-1:0]             meta_wr_addr;
   logic [MW-1:0]             meta_wr_data;
   logic                      meta_wr_en;

   // Entries are taken in order and never freed: valid entries are below the fill count
   assign fill_in = cmd.alloc ? fill_ff + FW'(1) : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Share one meta write port between allocation and updates
   always_comb begin
      if (cmd.alloc) begin
         meta_wr_addr = fill_ff[IW-1:0];
         meta_wr_data = '0;
      end else begin
         meta_wr_addr = meta_addr;
         meta_wr_data = {meta_wr_blocked, meta_wr_cnt, meta_wr_head};
      end
      meta_wr_en = cmd.alloc | cmd.meta_we;
   end

   // Key memory: written on allocation, read one entry a cycle during the search
   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         key_mem[fill_ff[IW-1:0]] <= alloc_key;
      end
      key_q_ff <= key_mem[key_rd_addr];
   end

   // Meta memory: blocked mark, count in window and ring head per entry
   always_ff @(posedge clock) begin
      if (meta_wr_en) begin
         meta_mem[meta_wr_addr] <= meta_wr_data;
      end
      meta_q_ff <= meta_mem[meta_addr];
   end

   assign key_q          = key_q_ff;
   assign meta_blocked_q = meta_q_ff[MW-1];
   assign meta_cnt_q     = meta_q_ff[CW+HW-1:HW];
   assign meta_head_q    = meta_q_ff[HW-1:0];
   assign fill           = fill_ff;

endmodule

/* rtl/core/slrl_stamp_ring.sv */
module slrl_stamp_ring #(
   parameter int SOURCES    = slrl_pkg::DEF_SOURCES,
   parameter int RING_DEPTH = slrl_pkg::DEF_RING_DEPTH
) (
   input  logic                              clock,
   input  logic [$clog2(SOURCES)-1:0]        entry,
   input  logic                              wr_en,
   input  logic [$clog2(RING_DEPTH)-1:0]     wr_pos,
   input  logic [$clog2(RING_DEPTH)-1:0]     rd_pos,
   input  logic [slrl_pkg::TIME_W-1:0]       now,
   input  logic [slrl_pkg::WINDOW_W-1:0]     window,
   output logic                              expired
);

   logic [slrl_pkg::TIME_W-1:0] stamp_mem [SOURCES][RING_DEPTH];
   logic [slrl_pkg::TIME_W-1:0] stamp_q_ff;
   logic [slrl_pkg::TIME_W-1:0] age;

   // Stamp memory: one ring per source, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stamp_mem[entry][wr_pos] <= now;
      end
      stamp_q_ff <= stamp_mem[entry][rd_pos];
   end

   // Age check of the oldest stamp against the window
   always_comb begin
      age     = now - stamp_q_ff;
      expired = (stamp_q_ff < now) && (age > slrl_pkg::TIME_W'(window));
   end

endmodule
